@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL modules of the graph search block.
// Needs i_clk and i_rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Condition holds on every clock edge out of reset
`define AST_HOLDS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("assertion failed");
// Antecedent in this cycle implies consequent in the same cycle
`define AST_IMPL(lbl, ant, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (cons)) \
        else $error("assertion failed");
// Antecedent in this cycle implies consequent in the next cycle
`define AST_NEXT(lbl, ant, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ hw/rtl/asng_pkg.sv @@
// Types and constants for the graph search block.
// No dependencies.
package asng_pkg;

    // Command codes on the input stream
    localparam logic [1:0] CMD_NODE   = 2'd0;
    localparam logic [1:0] CMD_DIST   = 2'd1;
    localparam logic [1:0] CMD_SEARCH = 2'd2;
    localparam logic [1:0] CMD_IGNORE = 2'd3;

    // Squared distance and root widths
    localparam int SQ_W = 36;
    localparam int RT_W = 18;
    localparam int SCORE_W = RT_W + 1;

    // Cost clamp limits on the 18-bit signed relaxed cost
    localparam logic signed [17:0] COST_HI = 18'sd32767;
    localparam logic signed [17:0] COST_LO = -18'sd32767;

    // Stream widths
    localparam int IN_TDATA_W  = 192;
    localparam int OUT_TDATA_W = 24;

    typedef enum logic [1:0] {
        OP_NODE   = 2'd0,
        OP_DIST   = 2'd1,
        OP_SEARCH = 2'd2
    } t_op;

    // One decoded command queued between front and back
    typedef struct packed {
        t_op                op;
        logic [4:0]         row;
        logic [4:0]         col;
        logic signed [15:0] dval;
        logic [4:0]         kind;
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [15:0] pz;
        logic [31:0]        link;
        logic [31:0]        lopen;
        logic [4:0]         start;
        logic [4:0]         goal;
        logic [31:0]        allowed;
    } t_cmd;

endpackage

@@ hw/rtl/asng_front.sv @@
// Front end: accepts input transfers, decodes and filters commands, queues them.
// Depends on asng_pkg and assert_macros.svh.
`include "assert_macros.svh"
module asng_front
    import asng_pkg::*;
#(
    parameter int MAX_NODES = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_TDATA_W-1:0] i_s_tdata,
    input  logic [1:0]            i_s_tuser,
    output logic                  o_q_valid,
    output t_cmd                  o_q_item,
    input  logic                  i_q_pop
);

    // Index wrap modulo the pool size, one compare and subtract per bit
    function automatic logic [4:0] wrap_idx(input logic [4:0] v);
        logic [10:0] t;
        t = {6'b0, v};
        for (int s = 4; s >= 0; s--) begin
            if (t >= (11'(MAX_NODES) << s)) begin
                t = t - (11'(MAX_NODES) << s);
            end
        end
        return t[4:0];
    endfunction

    t_cmd       w_cmd;
    logic       w_keep;
    logic       w_push;
    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_count;

    // Unpack and classify
    always_comb begin
        w_cmd.row     = i_s_tdata[4:0];
        w_cmd.col     = i_s_tdata[9:5];
        w_cmd.dval    = i_s_tdata[25:10];
        w_cmd.kind    = i_s_tdata[30:26];
        w_cmd.px      = i_s_tdata[46:31];
        w_cmd.py      = i_s_tdata[62:47];
        w_cmd.pz      = i_s_tdata[78:63];
        w_cmd.link    = i_s_tdata[110:79];
        w_cmd.lopen   = i_s_tdata[142:111];
        w_cmd.start   = wrap_idx(i_s_tdata[152:148]);
        w_cmd.goal    = wrap_idx(i_s_tdata[147:143]);
        w_cmd.allowed = i_s_tdata[184:153];
        w_cmd.op      = OP_NODE;
        w_keep        = 1'b0;
        case (i_s_tuser)
            CMD_NODE: begin
                w_cmd.op = OP_NODE;
                w_keep   = ({1'b0, w_cmd.row} < 6'(MAX_NODES));
            end
            CMD_DIST: begin
                w_cmd.op = OP_DIST;
                w_keep   = ({1'b0, w_cmd.row} < 6'(MAX_NODES)) &&
                           ({1'b0, w_cmd.col} < 6'(MAX_NODES));
            end
            CMD_SEARCH: begin
                w_cmd.op = OP_SEARCH;
                w_keep   = 1'b1;
            end
            default: begin
                w_keep = 1'b0;
            end
        endcase
    end

    assign o_s_tready = (r_count != 2'd2);
    assign w_push     = i_s_tvalid && o_s_tready && w_keep;
    assign o_q_valid  = (r_count != 2'd0);
    assign o_q_item   = r_mem[r_rp];

    // Two-entry queue
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            r_count <= r_count + 2'(w_push) - 2'(i_q_pop);
        end
    end

    `AST_HOLDS(a_count_max, r_count <= 2'd2)
    `AST_NEXT(a_push_only, w_push && !i_q_pop && r_count == 2'd0, r_count == 2'd1)

endmodule

@@ hw/rtl/asng_isqrt.sv @@
// Iterative floor square root, one result bit per cycle.
// Depends on asng_pkg.
module asng_isqrt
    import asng_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [SQ_W-1:0] i_val,
    output logic            o_done,
    output logic [RT_W-1:0] o_root
);

    logic [SQ_W-1:0]  r_val;
    logic [RT_W+1:0]  r_rem;
    logic [RT_W-1:0]  r_root;
    logic [4:0]       r_cnt;
    logic             r_busy;
    logic [RT_W+1:0]  w_rem_sh;
    logic [RT_W+1:0]  w_trial;
    logic             w_ge;

    // Bring down two bits, try appending a one
    assign w_rem_sh = {r_rem[RT_W-1:0], r_val[SQ_W-1 -: 2]};
    assign w_trial  = {r_root, 2'b01};
    assign w_ge     = (w_rem_sh >= w_trial);
    assign o_done   = r_busy && (r_cnt == 5'(RT_W - 1));
    assign o_root   = {r_root[RT_W-2:0], w_ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val  <= i_val;
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_val  <= {r_val[SQ_W-3:0], 2'b00};
            r_rem  <= w_ge ? (w_rem_sh - w_trial) : w_rem_sh;
            r_root <= {r_root[RT_W-2:0], w_ge};
            r_cnt  <= r_cnt + 5'd1;
        end
    end

endmodule

@@ hw/rtl/asng_back.sv @@
// Back end: node and distance stores, search sequencer and path output register.
// Depends on asng_pkg, asng_isqrt and assert_macros.svh.
`include "assert_macros.svh"
module asng_back
    import asng_pkg::*;
#(
    parameter int MAX_NODES = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_valid,
    input  t_cmd                   i_q_item,
    output logic                   o_q_pop,
    input  logic [5:0]             i_node_count,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    output logic                   o_m_tuser,
    output logic                   o_m_tlast
);

    localparam int IW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CW  = $clog2(MAX_NODES + 1);
    localparam int DD  = MAX_NODES * MAX_NODES;
    localparam int DAW = $clog2(DD);

    typedef enum logic [17:0] {
        S_IDLE  = 18'b000000000000000001,
        S_GOAL  = 18'b000000000000000010,
        S_GOAL2 = 18'b000000000000000100,
        S_START = 18'b000000000000001000,
        S_H0    = 18'b000000000000010000,
        S_H1    = 18'b000000000000100000,
        S_H2    = 18'b000000000001000000,
        S_H3    = 18'b000000000010000000,
        S_H4    = 18'b000000000100000000,
        S_PA    = 18'b000000001000000000,
        S_PB    = 18'b000000010000000000,
        S_PD    = 18'b000000100000000000,
        S_EA    = 18'b000001000000000000,
        S_XA    = 18'b000010000000000000,
        S_XB    = 18'b000100000000000000,
        S_WALK  = 18'b001000000000000000,
        S_FAIL  = 18'b010000000000000000,
        S_SPARE = 18'b100000000000000000
    } t_state;

    t_state r_state;

    // Node record stores, one write and one registered read port
    logic [4:0]         m_kind  [MAX_NODES];
    logic signed [15:0] m_px    [MAX_NODES];
    logic signed [15:0] m_py    [MAX_NODES];
    logic signed [15:0] m_pz    [MAX_NODES];
    logic [31:0]        m_link  [MAX_NODES];
    logic [31:0]        m_lopen [MAX_NODES];
    logic signed [15:0] m_dist  [DD];

    logic [4:0]         r_rd_kind;
    logic signed [15:0] r_rd_px;
    logic signed [15:0] r_rd_py;
    logic signed [15:0] r_rd_pz;
    logic [31:0]        r_rd_link;
    logic [31:0]        r_rd_lopen;
    logic signed [15:0] r_rd_dist;

    // Per-search working state
    logic [15:0]        r_cost   [MAX_NODES];
    logic [IW-1:0]      r_parent [MAX_NODES];
    logic [RT_W-1:0]    r_h      [MAX_NODES];
    logic [MAX_NODES-1:0] r_open;
    logic [MAX_NODES-1:0] r_closed;

    logic [IW-1:0]      r_start;
    logic [IW-1:0]      r_goal;
    logic [31:0]        r_allow;
    logic signed [15:0] r_gx, r_gy, r_gz;
    logic [CW-1:0]      r_i;
    logic [IW-1:0]      r_pick;
    logic               r_pv;
    logic [SCORE_W-1:0] r_best;
    logic [15:0]        r_pcost;
    logic [31:0]        r_lk, r_op;
    logic signed [16:0] r_dx, r_dy, r_dz;
    logic [33:0]        r_sqx, r_sqy, r_sqz;
    logic [IW-1:0]      r_node;
    logic [IW-1:0]      r_k;

    logic               r_ov;
    logic               r_of;
    logic [IW-1:0]      r_onode;
    logic [15:0]        r_ocost;
    logic               r_olast;

    logic [CW-1:0]      w_n;
    logic [CW-1:0]      w_inext;
    logic               w_ilast;
    logic [IW-1:0]      w_ii;
    logic [IW-1:0]      w_raddr;
    logic [DAW-1:0]     w_daddr;
    logic [DAW-1:0]     w_waddr;
    logic               w_ofree;
    logic               w_sq_start;
    logic [SQ_W-1:0]    w_sum;
    logic               w_sq_done;
    logic [RT_W-1:0]    w_root;
    logic [SCORE_W-1:0] w_score;
    logic               w_cand;
    logic signed [17:0] w_nc;
    logic signed [17:0] w_ncc;
    logic               w_relax;
    logic               w_wlast;

    assign w_n     = (i_node_count > 6'(MAX_NODES)) ? CW'(MAX_NODES) : CW'(i_node_count);
    assign w_inext = r_i + 1'b1;
    assign w_ilast = (w_inext == w_n);
    assign w_ii    = r_i[IW-1:0];
    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;
    assign w_ofree = !r_ov || i_m_tready;

    // Read address for the node record stores
    always_comb begin
        case (r_state)
            S_GOAL:  w_raddr = r_goal;
            S_GOAL2: w_raddr = r_start;
            S_PD:    w_raddr = r_pick;
            default: w_raddr = w_ii;
        endcase
    end

    assign w_daddr = DAW'(r_pick) * DAW'(MAX_NODES) + DAW'(w_ii);
    assign w_waddr = DAW'(i_q_item.row[IW-1:0]) * DAW'(MAX_NODES)
                   + DAW'(i_q_item.col[IW-1:0]);

    // Loads write the stores
    always_ff @(posedge i_clk) begin
        if (o_q_pop && i_q_item.op == OP_NODE) begin
            m_kind[i_q_item.row[IW-1:0]]  <= i_q_item.kind;
            m_px[i_q_item.row[IW-1:0]]    <= i_q_item.px;
            m_py[i_q_item.row[IW-1:0]]    <= i_q_item.py;
            m_pz[i_q_item.row[IW-1:0]]    <= i_q_item.pz;
            m_link[i_q_item.row[IW-1:0]]  <= i_q_item.link;
            m_lopen[i_q_item.row[IW-1:0]] <= i_q_item.lopen;
        end
        r_rd_kind  <= m_kind[w_raddr];
        r_rd_px    <= m_px[w_raddr];
        r_rd_py    <= m_py[w_raddr];
        r_rd_pz    <= m_pz[w_raddr];
        r_rd_link  <= m_link[w_raddr];
        r_rd_lopen <= m_lopen[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop && i_q_item.op == OP_DIST) begin
            m_dist[w_waddr] <= i_q_item.dval;
        end
        r_rd_dist <= m_dist[w_daddr];
    end

    // Heuristic: floor root of squared distance to the goal
    assign w_sum      = SQ_W'(r_sqx) + SQ_W'(r_sqy) + SQ_W'(r_sqz);
    assign w_sq_start = (r_state == S_H3);

    asng_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_val   (w_sum),
        .o_done  (w_sq_done),
        .o_root  (w_root)
    );

    // Candidate scoring and relaxation
    assign w_score = SCORE_W'(r_cost[w_ii]) + SCORE_W'(r_h[w_ii]);
    assign w_cand  = r_allow[r_rd_kind] && r_open[w_ii] && !r_closed[w_ii];
    assign w_nc    = $signed({2'b00, r_pcost}) + 18'(r_rd_dist);
    assign w_relax = r_lk[5'(w_ii)] && r_op[5'(w_ii)] && (w_ii != r_pick) &&
                     (!r_open[w_ii] || (w_nc < $signed({2'b00, r_cost[w_ii]})));
    assign w_ncc   = (w_nc < COST_LO) ? COST_LO : ((w_nc > COST_HI) ? COST_HI : w_nc);
    assign w_wlast = (r_node == r_start) || (r_k == IW'(MAX_NODES - 1));

    // Working arrays and datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_start <= i_q_item.start[IW-1:0];
                r_goal  <= i_q_item.goal[IW-1:0];
                r_allow <= i_q_item.allowed;
            end
            S_GOAL2: begin
                r_gx <= r_rd_px;
                r_gy <= r_rd_py;
                r_gz <= r_rd_pz;
            end
            S_START: begin
                r_parent[r_start] <= r_start;
                r_cost[r_start]   <= 16'd0;
                if (r_rd_link[5'(r_goal)]) begin
                    r_parent[r_goal] <= r_start;
                end
                r_node  <= r_goal;
                r_k     <= '0;
                r_pv    <= 1'b0;
                r_best  <= '1;
                r_i     <= '0;
            end
            S_H1: begin
                r_dx <= $signed({r_rd_px[15], r_rd_px}) - $signed({r_gx[15], r_gx});
                r_dy <= $signed({r_rd_py[15], r_rd_py}) - $signed({r_gy[15], r_gy});
                r_dz <= $signed({r_rd_pz[15], r_rd_pz}) - $signed({r_gz[15], r_gz});
            end
            S_H2: begin
                r_sqx <= 34'(r_dx * r_dx);
                r_sqy <= 34'(r_dy * r_dy);
                r_sqz <= 34'(r_dz * r_dz);
            end
            S_H4: begin
                if (w_sq_done) begin
                    r_h[w_ii] <= w_root;
                    r_i       <= w_ilast ? '0 : w_inext;
                end
            end
            S_PB: begin
                if (w_cand && w_score <= r_best) begin
                    r_best  <= w_score;
                    r_pick  <= w_ii;
                    r_pv    <= 1'b1;
                    r_pcost <= r_cost[w_ii];
                end
                r_i <= w_ilast ? '0 : w_inext;
            end
            S_PD: begin
                r_node <= r_goal;
                r_k    <= '0;
                r_i    <= '0;
            end
            S_EA: begin
                r_lk <= r_rd_link;
                r_op <= r_rd_lopen;
            end
            S_XB: begin
                if (w_relax) begin
                    r_parent[w_ii] <= r_pick;
                    r_cost[w_ii]   <= w_ncc[15:0];
                end
                if (w_ilast) begin
                    r_i    <= '0;
                    r_pv   <= 1'b0;
                    r_best <= '1;
                end else begin
                    r_i <= w_inext;
                end
            end
            S_WALK: begin
                if (w_ofree && !w_wlast) begin
                    r_node <= r_parent[r_node];
                    r_k    <= r_k + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Open and closed marks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open   <= '0;
            r_closed <= '0;
        end else if (r_state == S_START) begin
            r_open   <= '0;
            r_closed <= '0;
            r_open[r_start] <= 1'b1;
        end else if (r_state == S_PD && r_pv && r_pick != r_goal) begin
            r_closed[r_pick] <= 1'b1;
        end else if (r_state == S_XB && w_relax) begin
            r_open[w_ii] <= 1'b1;
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (o_q_pop && i_q_item.op == OP_SEARCH) begin
                        r_state <= S_GOAL;
                    end
                end
                S_GOAL: r_state <= S_GOAL2;
                S_GOAL2: begin
                    if ((r_rd_link & ~(32'd1 << r_goal)) == 32'd0) begin
                        r_state <= S_FAIL;
                    end else begin
                        r_state <= S_START;
                    end
                end
                S_START: begin
                    if (r_rd_link[5'(r_goal)]) begin
                        r_state <= S_WALK;
                    end else if (w_n == '0) begin
                        r_state <= S_PD;
                    end else begin
                        r_state <= S_H0;
                    end
                end
                S_H0: r_state <= S_H1;
                S_H1: r_state <= S_H2;
                S_H2: r_state <= S_H3;
                S_H3: r_state <= S_H4;
                S_H4: begin
                    if (w_sq_done) begin
                        r_state <= w_ilast ? S_PA : S_H0;
                    end
                end
                S_PA: r_state <= S_PB;
                S_PB: r_state <= w_ilast ? S_PD : S_PA;
                S_PD: begin
                    if (!r_pv) begin
                        r_state <= S_FAIL;
                    end else if (r_pick == r_goal) begin
                        r_state <= S_WALK;
                    end else begin
                        r_state <= S_EA;
                    end
                end
                S_EA: r_state <= S_XA;
                S_XA: r_state <= S_XB;
                S_XB: r_state <= w_ilast ? S_PA : S_XA;
                S_WALK: begin
                    if (w_ofree && w_wlast) begin
                        r_state <= S_IDLE;
                    end
                end
                S_FAIL: begin
                    if (w_ofree) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if ((r_state == S_WALK || r_state == S_FAIL) && w_ofree) begin
            r_ov <= 1'b1;
        end else if (i_m_tready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ofree) begin
            if (r_state == S_WALK) begin
                r_of    <= 1'b1;
                r_onode <= r_node;
                r_ocost <= r_open[r_node] ? r_cost[r_node] : 16'd0;
                r_olast <= w_wlast;
            end else if (r_state == S_FAIL) begin
                r_of    <= 1'b0;
                r_onode <= '0;
                r_ocost <= 16'd0;
                r_olast <= 1'b1;
            end
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {3'b000, r_ocost, 5'(r_onode)};
    assign o_m_tuser  = r_of;
    assign o_m_tlast  = r_olast;

    `AST_IMPL(a_pop_idle, o_q_pop, r_state == S_IDLE)
    `AST_IMPL(a_walk_start_open, r_state == S_WALK, r_open[r_start])
    `AST_IMPL(a_pick_unclosed, r_state == S_PD && r_pv, !r_closed[r_pick])
    `AST_IMPL(a_root_wait, w_sq_done, r_state == S_H4)

endmodule

@@ hw/rtl/a_star_node_graph_search.sv @@
// A* search over a pool of up to MAX_NODES nodes. Load commands (node record,
// distance entry) stream in back to back. A search holds off further
// commands until its path is out: setup, then for each node of node_count a
// goal-distance pass (fetch, difference and square, then a bit-serial square
// root), then for each expansion a scan of the candidates, a pick, a link
// fetch and a relaxation pass over the distance memory, then the path, one
// node per cycle while the result stream does not stall. If the start links
// straight to the goal, the passes are skipped. Results are goal first; tlast
// marks the start node, the MAX_NODES-th path entry, or the failure result.
// Config: node_count on i_cfg_data, written while idle.
// Depends on asng_pkg, asng_front and asng_back.
module a_star_node_graph_search
    import asng_pkg::*;
#(
    parameter int MAX_NODES = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [5:0]             i_cfg_data,   // node_count
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // node_index, column_index, distance_value, node_kind, pos_x, pos_y,
    // pos_z, link_mask, link_open_mask, start_goal, allowed_types, zero pad
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  logic [1:0]             i_s_tuser,    // cmd
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,    // path_node, path_cost, zero pad
    output logic                   o_m_tuser,    // found
    output logic                   o_m_tlast     // last
);

    logic [5:0] r_node_count;
    logic       w_q_valid;
    logic       w_q_pop;
    t_cmd       w_q_item;

    // Configuration register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= 6'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_node_count <= i_cfg_data;
        end
    end

    asng_front #(
        .MAX_NODES (MAX_NODES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_q_valid  (w_q_valid),
        .o_q_item   (w_q_item),
        .i_q_pop    (w_q_pop)
    );

    asng_back #(
        .MAX_NODES (MAX_NODES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (w_q_valid),
        .i_q_item     (w_q_item),
        .o_q_pop      (w_q_pop),
        .i_node_count (r_node_count),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_m_tdata    (o_m_tdata),
        .o_m_tuser    (o_m_tuser),
        .o_m_tlast    (o_m_tlast)
    );

endmodule
